@@ rtl/irpfd_pkg.sv @@
// Shared types and constants for the IR pulse frame decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package irpfd_pkg;

    localparam int unsigned FRAME_BITS = 32;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned US_W       = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LIM  = 3'd4;

    // Threshold values after reset.
    localparam logic [US_W-1:0] RST_MIN_VALID  = 16'd250;
    localparam logic [US_W-1:0] RST_ZERO_LIMIT = 16'd1200;
    localparam logic [US_W-1:0] RST_ONE_LIMIT  = 16'd2000;
    localparam logic [US_W-1:0] RST_REP_LIMIT  = 16'd3000;
    localparam logic [US_W-1:0] RST_START_LIM  = 16'd6000;

    // Frame state codes as seen on o_frame_state.
    localparam logic [1:0] FS_UNKNOWN  = 2'd0;
    localparam logic [1:0] FS_INCOMING = 2'd1;
    localparam logic [1:0] FS_READY    = 2'd2;
    localparam logic [1:0] FS_ERROR    = 2'd3;

    typedef enum logic [2:0] {
        PC_NONE,
        PC_ZERO,
        PC_ONE,
        PC_REPEAT,
        PC_START
    } t_pulse_class;

    typedef struct packed {
        logic [US_W-1:0] min_valid;
        logic [US_W-1:0] zero_limit;
        logic [US_W-1:0] one_limit;
        logic [US_W-1:0] rep_limit;
        logic [US_W-1:0] start_limit;
    } t_thresholds;

    typedef struct packed {
        logic [1:0]            frame_state;
        logic                  new_frame;
        logic [FRAME_BITS-1:0] frame;
    } t_result;

endpackage

@@ rtl/ir_pulse_frame_decoder.sv @@
// IR pulse frame decoder, NEC-style pulse-distance frames.
// An accepted request is held in the input register, then decoded into the output register
// when that register is free; the frame state updates once per decoded pulse.
// Throughput: one request per cycle while the result channel does not stall.
// Reset (synchronous, active low): thresholds return to 250/1200/2000/3000/6000 us,
// frame state to unknown, shift word, bit count and held frame to zero, pipe empties.
// Depends on irpfd_pkg, irpfd_classify, irpfd_core.
`timescale 1ns / 1ps

module ir_pulse_frame_decoder
    import irpfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [US_W-1:0]      i_cfg_data,
    // pulse request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [US_W-1:0]      i_pulse_width_us,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_frame_state,
    output logic                 o_new_frame,
    output logic [7:0]           o_address_byte,
    output logic [7:0]           o_inv_address_byte,
    output logic [7:0]           o_command_byte,
    output logic [7:0]           o_inv_command_byte
);

    // Threshold registers.
    t_thresholds r_thr;

    // Input register: holds one request waiting for the decode stage.
    logic            r_in_vld;
    logic [US_W-1:0] r_in_pulse;

    // Result register.
    logic            r_out_vld;
    t_result         r_out;

    logic            w_out_free;
    logic            w_fire;
    logic            w_in_take;
    t_pulse_class    w_class;
    t_result         w_result;

    // The result register frees up when empty or when its request is taken this cycle.
    assign w_out_free = !r_out_vld || !i_out_stall;
    // Decode the held request when the result register can take its answer.
    assign w_fire     = r_in_vld && w_out_free;
    // Accept a new request when the input register is empty or drains now.
    assign o_in_stall = r_in_vld && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.min_valid   <= RST_MIN_VALID;
            r_thr.zero_limit  <= RST_ZERO_LIMIT;
            r_thr.one_limit   <= RST_ONE_LIMIT;
            r_thr.rep_limit   <= RST_REP_LIMIT;
            r_thr.start_limit <= RST_START_LIM;
        end else if (i_cfg_we) begin
            // Drop writes to indexes past the last register.
            unique case (i_cfg_idx)
                CFG_MIN_VALID:  r_thr.min_valid   <= i_cfg_data;
                CFG_ZERO_LIMIT: r_thr.zero_limit  <= i_cfg_data;
                CFG_ONE_LIMIT:  r_thr.one_limit   <= i_cfg_data;
                CFG_REP_LIMIT:  r_thr.rep_limit   <= i_cfg_data;
                CFG_START_LIM:  r_thr.start_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: valid bit is control, pulse value is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_pulse <= i_pulse_width_us;
        end
    end

    irpfd_classify u_classify (
        .i_pulse_us (r_in_pulse),
        .i_thr      (r_thr),
        .o_class    (w_class)
    );

    irpfd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_class  (w_class),
        .o_result (w_result)
    );

    // Result register: load on decode, clear valid once the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_frame_state      = r_out.frame_state;
    assign o_new_frame        = r_out.new_frame;
    // Held frame bytes, low to high: address, inverted address, command, inverted command.
    assign o_address_byte     = r_out.frame[7:0];
    assign o_inv_address_byte = r_out.frame[15:8];
    assign o_command_byte     = r_out.frame[23:16];
    assign o_inv_command_byte = r_out.frame[31:24];

endmodule

@@ rtl/irpfd_classify.sv @@
// Pulse classifier: sorts one interval into a pulse class.
// Depends on irpfd_pkg.
`timescale 1ns / 1ps

module irpfd_classify
    import irpfd_pkg::*;
(
    input  logic [US_W-1:0] i_pulse_us,
    input  t_thresholds     i_thr,
    output t_pulse_class    o_class
);

    // Priority order matters: an empty window never wins.
    always_comb begin
        if (i_pulse_us < i_thr.min_valid) begin
            o_class = PC_NONE;
        end else if (i_pulse_us < i_thr.zero_limit) begin
            o_class = PC_ZERO;
        end else if (i_pulse_us < i_thr.one_limit) begin
            o_class = PC_ONE;
        end else if (i_pulse_us < i_thr.rep_limit) begin
            o_class = PC_REPEAT;
        end else if (i_pulse_us < i_thr.start_limit) begin
            o_class = PC_START;
        end else begin
            o_class = PC_NONE;
        end
    end

endmodule

@@ rtl/irpfd_core.sv @@
// Frame assembly state: shift word, bit count, decode state, held frame.
// Depends on irpfd_pkg.
`timescale 1ns / 1ps

module irpfd_core
    import irpfd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_fire,
    input  t_pulse_class i_class,
    output t_result      o_result
);

    typedef enum logic [1:0] {
        ST_UNKNOWN  = FS_UNKNOWN,
        ST_INCOMING = FS_INCOMING,
        ST_READY    = FS_READY,
        ST_ERROR    = FS_ERROR
    } t_state;

    t_state                r_state, n_state;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [FRAME_BITS-1:0] r_held,  n_held;
    logic                  n_latched;
    logic                  w_check_ok;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FRAME_BITS);

    assign w_check_ok = (r_shift[7:0]   == ~r_shift[15:8]) &&
                        (r_shift[23:16] == ~r_shift[31:24]);

    always_comb begin
        n_state   = r_state;
        n_shift   = r_shift;
        n_count   = r_count;
        n_held    = r_held;
        n_latched = 1'b0;
        if (i_fire) begin
            if (i_class == PC_START) begin
                n_state = ST_INCOMING;
                n_shift = '0;
                n_count = '0;
            end else if (r_state == ST_INCOMING) begin
                if (r_count >= FULL_COUNT) begin
                    if (w_check_ok) begin
                        n_held    = r_shift;
                        n_state   = ST_READY;
                        n_latched = 1'b1;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end else begin
                    case (i_class)
                        PC_ZERO: begin
                            n_shift = {1'b0, r_shift[FRAME_BITS-1:1]};
                            n_count = r_count + CNT_W'(1);
                        end
                        PC_ONE: begin
                            n_shift = {1'b1, r_shift[FRAME_BITS-1:1]};
                            n_count = r_count + CNT_W'(1);
                        end
                        PC_REPEAT: begin
                            if (r_count == '0) begin
                                n_count = FULL_COUNT;
                            end
                        end
                        default: begin
                            n_count = '0;
                        end
                    endcase
                end
            end
        end
    end

    assign o_result.frame_state = n_state;
    assign o_result.new_frame   = n_latched;
    assign o_result.frame       = n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_UNKNOWN;
            r_shift <= '0;
            r_count <= '0;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            r_shift <= n_shift;
            r_count <= n_count;
            r_held  <= n_held;
        end
    end

endmodule

@@ rtl/irpfd_checker.sv @@
// Port-level checks for the IR pulse frame decoder, bound to the top level.
// Depends on irpfd_pkg and ir_pulse_frame_decoder.
`timescale 1ns / 1ps

module irpfd_checker
    import irpfd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [1:0]           o_frame_state,
    input logic                 o_new_frame,
    input logic [7:0]           o_address_byte,
    input logic [7:0]           o_inv_address_byte,
    input logic [7:0]           o_command_byte,
    input logic [7:0]           o_inv_command_byte
);

    // A freshly latched frame always reports the ready state.
    a_new_is_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_new_frame) |-> (o_frame_state == FS_READY))
        else $error("new frame without ready state");

    // A latched frame passed both byte checks.
    a_new_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_new_frame) |->
            ((o_address_byte == ~o_inv_address_byte) &&
             (o_command_byte == ~o_inv_command_byte)))
        else $error("latched frame fails inversion check");

    // Results never appear without a request: the pipe is empty after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_frame_state) && $stable(o_new_frame) &&
             $stable(o_address_byte) && $stable(o_command_byte)))
        else $error("stalled result changed");

endmodule

bind ir_pulse_frame_decoder irpfd_checker u_irpfd_checker (.*);

@@ bench/tb.sv @@
// Self-checking bench for ir_pulse_frame_decoder: random pulse streams checked cycle by cycle.
// Holds its own decoder model; depends only on irpfd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb
    import irpfd_pkg::*;
();

    // Cycles with work pending but no handshake on either channel before giving up.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to let pass after the last result (output pipe is two deep).
    localparam int DRAIN_CYCLES   = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_MIN_VALID;
    logic [US_W-1:0]      i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [US_W-1:0]      i_pulse_width_us = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_frame_state;
    logic                 o_new_frame;
    logic [7:0]           o_address_byte;
    logic [7:0]           o_inv_address_byte;
    logic [7:0]           o_command_byte;
    logic [7:0]           o_inv_command_byte;

    ir_pulse_frame_decoder dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_pulse_width_us   (i_pulse_width_us),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_frame_state      (o_frame_state),
        .o_new_frame        (o_new_frame),
        .o_address_byte     (o_address_byte),
        .o_inv_address_byte (o_inv_address_byte),
        .o_command_byte     (o_command_byte),
        .o_inv_command_byte (o_inv_command_byte)
    );

    // ------------------------------------------------------------------
    // Decoder model: thresholds, frame assembly state and the expectations
    // it produces, one per accepted pulse request.
    // ------------------------------------------------------------------
    logic [US_W-1:0]       thresh [5] = '{RST_MIN_VALID, RST_ZERO_LIMIT, RST_ONE_LIMIT,
                                          RST_REP_LIMIT, RST_START_LIM};
    logic [FRAME_BITS-1:0] shift_bits   = '0;
    logic [CNT_W-1:0]      bits_held    = '0;
    logic [1:0]            rx_state     = FS_UNKNOWN;
    logic [FRAME_BITS-1:0] last_frame   = '0;

    logic [US_W-1:0] pending_pulses [$];
    t_result         expected_decodes [$];

    int mismatch_count = 0;

    // Thresholds are tested strictly in order; an empty window simply never matches.
    function automatic t_pulse_class classify_width(input logic [US_W-1:0] w);
        if (w < thresh[CFG_MIN_VALID])  return PC_NONE;
        if (w < thresh[CFG_ZERO_LIMIT]) return PC_ZERO;
        if (w < thresh[CFG_ONE_LIMIT])  return PC_ONE;
        if (w < thresh[CFG_REP_LIMIT])  return PC_REPEAT;
        if (w < thresh[CFG_START_LIM])  return PC_START;
        return PC_NONE;
    endfunction

    // Advance the frame assembler by one pulse and queue the result it implies.
    task automatic decode_pulse(input logic [US_W-1:0] w);
        t_pulse_class pc;
        t_result      res;
        logic         latched;
        pc = classify_width(w);
        latched = 1'b0;
        if (pc == PC_START) begin
            rx_state   = FS_INCOMING;
            shift_bits = '0;
            bits_held  = '0;
        end else if (rx_state == FS_INCOMING) begin
            if (bits_held >= FRAME_BITS) begin
                // Any non-start pulse after a full frame triggers the byte checks.
                if (shift_bits[7:0] == ~shift_bits[15:8] &&
                    shift_bits[23:16] == ~shift_bits[31:24]) begin
                    last_frame = shift_bits;
                    rx_state   = FS_READY;
                    latched    = 1'b1;
                end else begin
                    rx_state = FS_ERROR;
                end
            end else if (pc == PC_ZERO) begin
                shift_bits = {1'b0, shift_bits[FRAME_BITS-1:1]};
                bits_held  = bits_held + CNT_W'(1);
            end else if (pc == PC_ONE) begin
                shift_bits = {1'b1, shift_bits[FRAME_BITS-1:1]};
                bits_held  = bits_held + CNT_W'(1);
            end else if (pc == PC_REPEAT) begin
                // Repeat code only counts while the bit count is zero: after a start or after noise.
                if (bits_held == '0) bits_held = CNT_W'(FRAME_BITS);
            end else begin
                // Noise mid-frame drops the bit count but keeps the shifted bits.
                bits_held = '0;
            end
        end
        res.frame_state = rx_state;
        res.new_frame   = latched;
        res.frame       = last_frame;
        expected_decodes.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Pick a width that falls into the given class under the current thresholds.
    // Class codes from ZERO to START line up with the threshold that closes their window.
    function automatic logic [US_W-1:0] pick_width(input t_pulse_class pc);
        int lo;
        int hi;
        lo = 0;
        if (pc == PC_NONE) begin
            if (thresh[CFG_MIN_VALID] > 0 && $urandom_range(0, 1) == 1) begin
                hi = int'(thresh[CFG_MIN_VALID]) - 1;
            end else begin
                for (int k = 0; k < 5; k++) if (int'(thresh[k]) > lo) lo = int'(thresh[k]);
                hi = 65535;
            end
        end else begin
            for (int k = 0; k < int'(pc); k++) if (int'(thresh[k]) > lo) lo = int'(thresh[k]);
            hi = int'(thresh[int'(pc)]) - 1;
            // Empty window: the class cannot be produced, send anything.
            if (hi < lo) return US_W'($urandom_range(0, 65535));
        end
        case ($urandom_range(0, 7))
            0: return US_W'(lo);
            1: return US_W'(hi);
            default: return US_W'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic push_pulse(input t_pulse_class pc);
        pending_pulses.push_back(pick_width(pc));
    endtask

    // Full frame, LSB first, closed by any non-start pulse that triggers the check.
    task automatic push_frame(input bit corrupt);
        logic [7:0]            addr;
        logic [7:0]            cmd;
        logic [FRAME_BITS-1:0] word;
        int                    flip;
        addr = 8'($urandom);
        cmd  = 8'($urandom);
        word = {~cmd, cmd, ~addr, addr};
        if (corrupt) begin
            flip = $urandom_range(0, FRAME_BITS - 1);
            word[flip] = ~word[flip];
        end
        push_pulse(PC_START);
        for (int i = 0; i < FRAME_BITS; i++) push_pulse(word[i] ? PC_ONE : PC_ZERO);
        push_pulse(t_pulse_class'($urandom_range(0, 3)));
    endtask

    // Start, some bits, then an arbitrary pulse that may break the frame.
    task automatic push_broken_frame();
        int nbits;
        nbits = $urandom_range(0, FRAME_BITS - 1);
        push_pulse(PC_START);
        for (int i = 0; i < nbits; i++) push_pulse($urandom_range(0, 1) ? PC_ONE : PC_ZERO);
        push_pulse(t_pulse_class'($urandom_range(0, 4)));
    endtask

    task automatic push_random_traffic(input int n_items);
        int target;
        int r;
        target = pending_pulses.size() + n_items;
        while (pending_pulses.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                push_frame(1'b0);
            end else if (r < 65) begin
                push_frame(1'b1);
            end else if (r < 75) begin
                // Repeat code: start, repeat, then the pulse that checks the empty word.
                push_pulse(PC_START);
                push_pulse(PC_REPEAT);
                push_pulse(t_pulse_class'($urandom_range(0, 3)));
            end else if (r < 90) begin
                push_broken_frame();
            end else begin
                repeat ($urandom_range(1, 5)) pending_pulses.push_back(US_W'($urandom));
            end
        end
    endtask

    // Hold until every request went in and every result came back.
    task automatic wait_idle();
        while (pending_pulses.size() != 0 || i_in_valid || expected_decodes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [US_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        thresh[idx] = val;
    endtask

    task automatic set_thresholds(input int mv, input int zl, input int ol,
                                  input int rl, input int sl);
        cfg_write(CFG_MIN_VALID,  US_W'(mv));
        cfg_write(CFG_ZERO_LIMIT, US_W'(zl));
        cfg_write(CFG_ONE_LIMIT,  US_W'(ol));
        cfg_write(CFG_REP_LIMIT,  US_W'(rl));
        cfg_write(CFG_START_LIM,  US_W'(sl));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Request driver: pops the pending queue, presents one pulse at a time,
    // feeds the model on each accepted request, then idles for a drawn gap.
    // ------------------------------------------------------------------
    int gap_left  = 0;
    bit src_burst = 1'b0;

    always @(posedge i_clk) begin
        logic next_valid;
        if (i_rst_n) begin
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                decode_pulse(i_pulse_width_us);
                next_valid = 1'b0;
                gap_left   = src_burst ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_pulses.size() != 0) begin
                    next_valid = 1'b1;
                    i_pulse_width_us <= pending_pulses.pop_front();
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each accepted result against the oldest
    // expectation, then stalls the result channel for a drawn count of
    // cycles in which a result is on offer.
    // ------------------------------------------------------------------
    int stall_left = 0;
    bit snk_burst  = 1'b0;

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_decodes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got state %0d",
                             $time, o_frame_state);
                    mismatch_count++;
                end else begin
                    exp_r = expected_decodes.pop_front();
                    check_field("frame_state", 32'(exp_r.frame_state), 32'(o_frame_state));
                    check_field("new_frame", 32'(exp_r.new_frame), 32'(o_new_frame));
                    check_field("address_byte", 32'(exp_r.frame[7:0]),
                                32'(o_address_byte));
                    check_field("inv_address_byte", 32'(exp_r.frame[15:8]),
                                32'(o_inv_address_byte));
                    check_field("command_byte", 32'(exp_r.frame[23:16]),
                                32'(o_command_byte));
                    check_field("inv_command_byte", 32'(exp_r.frame[31:24]),
                                32'(o_inv_command_byte));
                end
                stall_left = snk_burst ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
            end else if (o_out_valid && stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles that have work pending but no handshake.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (pending_pulses.size() == 0 && !i_in_valid && expected_decodes.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence: directed pulses on reset thresholds, then phases of
    // random traffic, each under a freshly written threshold set.
    // ------------------------------------------------------------------
    initial begin
        int v [$];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Window edges while idle (only starts act), then the corner paths:
        // noise after a repeat code checks an all-zero word, noise mid-frame
        // clears the count, a repeat after bits is dropped, a start restarts.
        pending_pulses = '{16'd0, 16'd65535, 16'd249, 16'd250, 16'd1199, 16'd1200,
                           16'd1999, 16'd2000, 16'd2999,
                           16'd3000, 16'd2999, 16'd6000,
                           16'd5999, 16'd250, 16'd1999, 16'd65535, 16'd2000, 16'd1200,
                           16'd4000, 16'd1000, 16'd2500, 16'd5999, 16'd1500, 16'd100};
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_thresholds(RST_MIN_VALID, RST_ZERO_LIMIT, RST_ONE_LIMIT,
                                  RST_REP_LIMIT, RST_START_LIM);
                1, 6: begin
                    v = {};
                    repeat (5) v.push_back($urandom_range(0, 20000));
                    v.sort();
                    set_thresholds(v[0], v[1], v[2], v[3], v[4]);
                end
                2: set_thresholds(0, 1, 2, 3, 4);
                3: set_thresholds(65535, 65535, 65535, 65535, 65535);
                4: set_thresholds(0, 0, 0, 0, 0);
                5: set_thresholds($urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535));
                default: set_thresholds(0, 16, 32, 48, 65535);
            endcase
            // Degenerate threshold sets turn everything into noise; keep those short.
            push_random_traffic((phase == 3 || phase == 4) ? 40 : 150);
            wait_idle();
        end

        if (mismatch_count == 0 && expected_decodes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
